/* design/thrpwm_pkg.sv */
`timescale 1ns / 1ps

package thrpwm_pkg;

    localparam int CH_W     = 3;
    localparam int THR_W    = 16;
    localparam int PULSE_W  = 12;
    localparam int FREQ_W   = 16;
    localparam int WRAP_W   = 16;
    localparam int LEVEL_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam int Q_W   = 17;
    localparam int DEN_W = 36;
    localparam int DV_W  = DEN_W + 1;
    localparam int REM_W = DV_W + Q_W;
    localparam int P_W   = 63;
    localparam int N_W   = P_W + 2;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP     = 3'd5;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            err;
        logic            live;
    } t_side;

endpackage

/* design/thrpwm_div.sv */
`timescale 1ns / 1ps

module thrpwm_div
    import thrpwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  logic [REM_W-1:0] i_rem,
    input  logic             i_ovf,
    input  t_side            i_side,
    input  logic [DV_W-1:0]  i_dv,
    output logic             o_vld,
    input  logic             i_rdy,
    output logic [Q_W-1:0]   o_q,
    output logic             o_ovf,
    output t_side            o_side
);

    logic [Q_W:0]     w_rdy;
    logic [Q_W-1:0]   r_vld;
    logic [REM_W-1:0] r_rem  [Q_W-1];
    logic [Q_W-1:0]   r_q    [Q_W];
    logic [Q_W-1:0]   r_ovf;
    t_side            r_side [Q_W];

    assign w_rdy[Q_W] = i_rdy;

    for (genvar j = 0; j < Q_W; j++) begin : g_st
        logic             w_vld_in;
        logic [REM_W-1:0] w_rem_in;
        logic [Q_W-1:0]   w_q_in;
        logic             w_ovf_in;
        t_side            w_side_in;
        logic [REM_W-1:0] w_dsh;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_rem;
            assign w_q_in    = '0;
            assign w_ovf_in  = i_ovf;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[j-1];
            assign w_rem_in  = r_rem[j-1];
            assign w_q_in    = r_q[j-1];
            assign w_ovf_in  = r_ovf[j-1];
            assign w_side_in = r_side[j-1];
        end

        assign w_rdy[j] = ~r_vld[j] | w_rdy[j+1];
        assign w_dsh    = REM_W'(i_dv) << (Q_W - 1 - j);
        assign w_ge     = (w_rem_in >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_vld[j] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_q[j]    <= {w_q_in[Q_W-2:0], w_ge};
                r_ovf[j]  <= w_ovf_in;
                r_side[j] <= w_side_in;
            end
        end

        if (j < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_rdy[j]) begin
                    r_rem[j] <= w_ge ? (w_rem_in - w_dsh) : w_rem_in;
                end
            end
        end
    end

    assign o_rdy  = w_rdy[0];
    assign o_vld  = r_vld[Q_W-1];
    assign o_q    = r_q[Q_W-1];
    assign o_ovf  = r_ovf[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

/* design/throttle_to_pwm_level_core.sv */
`timescale 1ns / 1ps

// Maps a throttle command onto a PWM compare level for one motor channel. The throttle is
// scaled linearly from [throttle_low, throttle_high] onto the pulse range in microseconds,
// and the pulse becomes pulse * pwm_freq_hz * (counter_wrap + 1) / 1e6, rounded half up,
// clamped to 0 below and to counter_wrap above; an empty throttle range flags config_error
// and gives level 0, and a channel at or above NUM_CHANNELS gives level 0 without the flag.
// The block takes one beat per clock while the output is not stalled; each beat passes
// through seven arithmetic stages, a 17-stage restoring divider that settles one quotient
// bit per stage, and then the output register. Stalls on the
// output fill empty stages first. Registers should be written only with no beat in flight.

module throttle_to_pwm_level_core
    import thrpwm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // channel [2:0], throttle [18:3], zeros [23:19]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_channel [2:0], level [18:3], zeros [23:19]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // config_error [0]
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    logic signed [THR_W-1:0]   r_thr_low;
    logic signed [THR_W-1:0]   r_thr_high;
    logic        [PULSE_W-1:0] r_pulse_min;
    logic        [PULSE_W-1:0] r_pulse_max;
    logic        [FREQ_W-1:0]  r_freq;
    logic        [WRAP_W-1:0]  r_wrap;

    logic signed [THR_W:0]     w_d;
    logic                      r_rng_err;
    logic        [THR_W-1:0]   r_d16;
    logic signed [PULSE_W:0]   r_dp;
    logic        [31:0]        r_f;
    logic        [27:0]        r_a;
    logic        [DEN_W-1:0]   r_den;
    logic        [DV_W-1:0]    w_dv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low   <= 16'sd0;
            r_thr_high  <= 16'sd1000;
            r_pulse_min <= 12'd125;
            r_pulse_max <= 12'd250;
            r_freq      <= 16'd2000;
            r_wrap      <= 16'd9999;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THR_LOW:   r_thr_low   <= $signed(i_cfg_data);
                CFG_THR_HIGH:  r_thr_high  <= $signed(i_cfg_data);
                CFG_PULSE_MIN: r_pulse_min <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX: r_pulse_max <= i_cfg_data[PULSE_W-1:0];
                CFG_FREQ:      r_freq      <= i_cfg_data;
                CFG_WRAP:      r_wrap      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Terms that depend only on the registers, two levels deep.
    assign w_d  = 17'(r_thr_high) - 17'(r_thr_low);
    assign w_dv = {r_den, 1'b0};

    always_ff @(posedge i_clk) begin
        r_rng_err <= (w_d <= 17'sd0);
        r_d16     <= w_d[THR_W-1:0];
        r_dp      <= $signed({1'b0, r_pulse_max}) - $signed({1'b0, r_pulse_min});
        r_f       <= 32'(33'(r_freq) * (33'(r_wrap) + 33'd1));
        r_a       <= 28'(28'(r_pulse_min) * 28'(r_d16));
        r_den     <= 36'(36'(r_d16) * 36'(US_PER_S));
    end

    logic r_vld0, r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6, r_out_vld;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6, w_rdy_div, w_rdy_out;

    logic        [CH_W-1:0]  r_ch0, r_ch1, r_ch2;
    logic signed [THR_W-1:0] r_thr0;
    logic signed [THR_W:0]   r_t1;
    logic                    r_chok1, r_chok2, r_err2;
    logic signed [29:0]      r_b2;
    logic signed [31:0]      w_num;
    logic                    w_pos;
    logic        [30:0]      r_num3;
    t_side                   r_side3, r_side4, r_side5, r_side6;
    logic        [P_W-1:0]   r_p4;
    logic        [N_W-1:0]   r_n5;
    logic                    r_ovf6;
    logic        [REM_W-1:0] r_rem6;

    logic                    w_div_vld;
    logic        [Q_W-1:0]   w_div_q;
    logic                    w_div_ovf;
    t_side                   w_div_side;
    logic        [LEVEL_W-1:0] w_level;

    logic        [CH_W-1:0]    r_out_ch;
    logic        [LEVEL_W-1:0] r_out_level;
    logic                      r_out_err;

    assign w_rdy_out = ~r_out_vld | i_m_axis_tready;
    assign w_rdy6    = ~r_vld6 | w_rdy_div;
    assign w_rdy5    = ~r_vld5 | w_rdy6;
    assign w_rdy4    = ~r_vld4 | w_rdy5;
    assign w_rdy3    = ~r_vld3 | w_rdy4;
    assign w_rdy2    = ~r_vld2 | w_rdy3;
    assign w_rdy1    = ~r_vld1 | w_rdy2;
    assign w_rdy0    = ~r_vld0 | w_rdy1;
    assign o_s_axis_tready = w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_vld0 <= i_s_axis_tvalid;
            end
            if (w_rdy1) begin
                r_vld1 <= r_vld0;
            end
            if (w_rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (w_rdy3) begin
                r_vld3 <= r_vld2;
            end
            if (w_rdy4) begin
                r_vld4 <= r_vld3;
            end
            if (w_rdy5) begin
                r_vld5 <= r_vld4;
            end
            if (w_rdy6) begin
                r_vld6 <= r_vld5;
            end
        end
    end

    assign w_num = $signed({4'b0, r_a}) + 32'(r_b2);
    assign w_pos = ~w_num[31] & (|w_num[30:0]);

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_ch0  <= i_s_axis_tdata[CH_W-1:0];
            r_thr0 <= $signed(i_s_axis_tdata[CH_W+THR_W-1:CH_W]);
        end
        if (w_rdy1) begin
            r_ch1   <= r_ch0;
            r_t1    <= 17'(r_thr0) - 17'(r_thr_low);
            r_chok1 <= (32'(r_ch0) < NUM_CHANNELS);
        end
        if (w_rdy2) begin
            r_ch2   <= r_ch1;
            r_chok2 <= r_chok1;
            r_err2  <= r_chok1 & r_rng_err;
            r_b2    <= 30'(r_t1) * 30'(r_dp);
        end
        if (w_rdy3) begin
            r_side3.ch   <= r_ch2;
            r_side3.err  <= r_err2;
            r_side3.live <= r_chok2 & ~r_err2 & w_pos;
            r_num3       <= w_num[30:0];
        end
        if (w_rdy4) begin
            r_side4 <= r_side3;
            r_p4    <= P_W'(r_num3) * P_W'(r_f);
        end
        if (w_rdy5) begin
            r_side5 <= r_side4;
            r_n5    <= {1'b0, r_p4, 1'b0} + N_W'(r_den);
        end
        if (w_rdy6) begin
            r_side6 <= r_side5;
            r_ovf6  <= (r_n5 >= N_W'({w_dv, {Q_W{1'b0}}}));
            r_rem6  <= r_n5[REM_W-1:0];
        end
    end

    thrpwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld6),
        .o_rdy   (w_rdy_div),
        .i_rem   (r_rem6),
        .i_ovf   (r_ovf6),
        .i_side  (r_side6),
        .i_dv    (w_dv),
        .o_vld   (w_div_vld),
        .i_rdy   (w_rdy_out),
        .o_q     (w_div_q),
        .o_ovf   (w_div_ovf),
        .o_side  (w_div_side)
    );

    always_comb begin
        if (!w_div_side.live) begin
            w_level = '0;
        end else if (w_div_ovf || (w_div_q > {1'b0, r_wrap})) begin
            w_level = r_wrap;
        end else begin
            w_level = w_div_q[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_out_ch    <= w_div_side.ch;
            r_out_level <= w_level;
            r_out_err   <= w_div_side.err;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - CH_W - LEVEL_W){1'b0}}, r_out_level, r_out_ch};
    assign o_m_axis_tuser  = r_out_err;

endmodule

/* design/thrpwm_chk.sv */
`timescale 1ns / 1ps

module thrpwm_chk
    import thrpwm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    // A stalled result beat must hold still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // An empty throttle range always yields a zero level.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            o_m_axis_tdata[CH_W+LEVEL_W-1:CH_W] == '0)
        else $error("config_error beat with nonzero level");

    // Channels outside the populated set give a zero level and no error.
    a_bad_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (32'(o_m_axis_tdata[CH_W-1:0]) >= NUM_CHANNELS) |->
            o_m_axis_tdata[CH_W+LEVEL_W-1:CH_W] == '0 && !o_m_axis_tuser)
        else $error("unpopulated channel produced a level");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind throttle_to_pwm_level_core thrpwm_chk #(.NUM_CHANNELS(NUM_CHANNELS)) u_chk (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import thrpwm_pkg::*;

    localparam int NUM_CHANNELS = 8;
    localparam int LATENCY      = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] level;
        logic               err;
    } t_level_result;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_cfg_ready;

    // Register copies used for prediction, at their reset values.
    logic signed [THR_W-1:0] thr_low_r   = 16'sd0;
    logic signed [THR_W-1:0] thr_high_r  = 16'sd1000;
    logic [PULSE_W-1:0]      pulse_min_r = 12'd125;
    logic [PULSE_W-1:0]      pulse_max_r = 12'd250;
    logic [FREQ_W-1:0]       freq_r      = 16'd2000;
    logic [WRAP_W-1:0]       wrap_r      = 16'd9999;

    t_level_result expected_levels[$];
    int       fail_count    = 0;
    int       n_sent        = 0;
    int       n_checked     = 0;
    int       n_flagged     = 0;
    int       n_writes      = 0;
    int       tx_burst_left = 0;
    int       tx_gap_max    = 0;
    t_rx_mode rx_mode       = RX_ALWAYS;
    int       rx_cycle      = 0;

    throttle_to_pwm_level_core #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(64'd20_000_000);
        $display("FAIL throttle_to_pwm_level_core");
        $finish;
    end

    function automatic t_level_result compute_level(input logic [CH_W-1:0] ch,
                                                    input logic [THR_W-1:0] thr);
        t_level_result res;
        longint lo;
        longint hi;
        longint span;
        longint pulse_span;
        longint num;
        logic [127:0] f;
        logic [127:0] den;
        logic [127:0] q;
        res.ch = ch;
        res.level = '0;
        res.err = 1'b0;
        lo = thr_low_r;
        hi = thr_high_r;
        if (ch < NUM_CHANNELS) begin
            if (hi <= lo) begin
                res.err = 1'b1;
            end else begin
                span = hi - lo;
                pulse_span = longint'(pulse_max_r) - longint'(pulse_min_r);
                num = longint'(pulse_min_r) * span
                      + (longint'($signed(thr)) - lo) * pulse_span;
                if (num > 0) begin
                    f = 128'(freq_r) * (128'(wrap_r) + 128'd1);
                    den = 128'(span) * 128'd1000000;
                    q = (128'd2 * 128'(num) * f + den) / (128'd2 * den);
                    res.level = (q > 128'(wrap_r)) ? wrap_r : q[LEVEL_W-1:0];
                end
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 35);
            RX_PERIODIC: m_tready <= ((rx_cycle % 13) >= 4);
            default:     m_tready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        t_level_result act;
        t_level_result exp_res;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            act.ch = o_m_axis_tdata[CH_W-1:0];
            act.level = o_m_axis_tdata[CH_W +: LEVEL_W];
            act.err = o_m_axis_tuser;
            if (expected_levels.size() == 0) begin
                note_failure($sformatf("unexpected beat: ch %0d level %0d err %0b",
                                       act.ch, act.level, act.err));
            end else begin
                exp_res = expected_levels.pop_front();
                n_checked++;
                if (exp_res.err) n_flagged++;
                if (act.ch !== exp_res.ch || act.level !== exp_res.level
                        || act.err !== exp_res.err) begin
                    note_failure($sformatf(
                        "mismatch: expected ch %0d level %0d err %0b, got ch %0d level %0d err %0b",
                        exp_res.ch, exp_res.level, exp_res.err,
                        act.ch, act.level, act.err));
                end
            end
        end
    end

    task automatic send_beat(input logic [CH_W-1:0] ch, input logic [THR_W-1:0] thr);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 12);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W - CH_W - THR_W){1'b0}}, thr, ch};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_levels.push_back(compute_level(ch, thr));
        n_sent++;
        tx_burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        tx_burst_left = 0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_THR_LOW:   thr_low_r = data;
            CFG_THR_HIGH:  thr_high_r = data;
            CFG_PULSE_MIN: pulse_min_r = data[PULSE_W-1:0];
            CFG_PULSE_MAX: pulse_max_r = data[PULSE_W-1:0];
            CFG_FREQ:      freq_r = data;
            CFG_WRAP:      wrap_r = data;
            default:       ;
        endcase
        n_writes++;
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [15:0] lo, input logic [15:0] hi,
                                input logic [15:0] pmin, input logic [15:0] pmax,
                                input logic [15:0] freq, input logic [15:0] wrap);
        wait_idle();
        write_reg(CFG_THR_LOW, lo, 1'b0);
        write_reg(CFG_THR_HIGH, hi, 1'b0);
        write_reg(CFG_PULSE_MIN, pmin, 1'b0);
        write_reg(CFG_PULSE_MAX, pmax, 1'b0);
        write_reg(CFG_FREQ, freq, 1'b0);
        write_reg(CFG_WRAP, wrap, 1'b1);
    endtask

    task automatic test_reset_values();
        send_beat(3'd0, 16'd0);
        send_beat(3'd7, 16'd1000);
        send_beat(3'd3, 16'd500);
        send_beat(3'd5, 16'h8000);
        send_beat(3'd2, 16'h7FFF);
        send_beat(3'd6, 16'h5555);
    endtask

    task automatic test_corner_settings();
        program_regs(16'h8000, 16'h7FFF, 16'd0, 16'd4095, 16'hFFFF, 16'hFFFF);
        send_beat(3'd1, 16'h8000);
        send_beat(3'd4, 16'h7FFF);
        send_beat(3'd6, 16'd0);
        // Empty and inverted throttle ranges raise the error flag.
        program_regs(16'd100, 16'd100, 16'd125, 16'd250, 16'd2000, 16'd9999);
        send_beat(3'd2, 16'd100);
        program_regs(16'd200, -16'sd5, 16'd125, 16'd250, 16'd2000, 16'd9999);
        send_beat(3'd7, 16'd50);
        program_regs(16'd0, 16'd1000, 16'd125, 16'd250, 16'd0, 16'd9999);
        send_beat(3'd0, 16'd500);
        program_regs(16'd0, 16'd1000, 16'd125, 16'd250, 16'd2000, 16'd0);
        send_beat(3'd3, 16'd700);
        program_regs(16'd0, 16'd1000, 16'd125, 16'd250, 16'd1, 16'd1);
        send_beat(3'd5, 16'd1000);
        // A falling pulse range drives the pulse negative beyond the high end.
        program_regs(16'd0, 16'd1000, 16'd4095, 16'd0, 16'd100, 16'hFFFF);
        send_beat(3'd1, 16'd0);
        send_beat(3'd2, 16'd1000);
        send_beat(3'd3, 16'd1100);
        program_regs(16'd0, 16'd1000, 16'd0, 16'd0, 16'd2000, 16'd9999);
        send_beat(3'd4, 16'd600);
        // The level lands exactly on one half and must round up.
        program_regs(16'd0, 16'd1, 16'd125, 16'd125, 16'd4, 16'd999);
        send_beat(3'd6, 16'd0);
        wait_idle();
        write_reg(CFG_SPARE_6, 16'hFFFF, 1'b0);
        write_reg(CFG_SPARE_7, 16'hFFFF, 1'b1);
        send_beat(3'd7, 16'd0);
    endtask

    task automatic test_random_settings();
        int kind;
        int lo_i;
        int hi_i;
        int thr_i;
        int pmin;
        int pmax;
        int freq;
        logic [15:0] pmin_w;
        logic [15:0] pmax_w;
        for (int phase = 0; phase < 9; phase++) begin
            kind = (phase < 3) ? phase : $urandom_range(0, 4);
            lo_i = $urandom_range(0, 2000) - 1000;
            hi_i = lo_i + $urandom_range(1, 3000);
            pmin = $urandom_range(0, 2047);
            pmax = $urandom_range(0, 4095);
            freq = $urandom_range(1, 1000000 / ((pmin > pmax ? pmin : pmax) + 1));
            pmin_w = {4'($urandom_range(0, 15)), 12'(pmin)};
            pmax_w = {4'($urandom_range(0, 15)), 12'(pmax)};
            if (kind == 1) begin
                program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            end else if (kind == 2) begin
                hi_i = lo_i - $urandom_range(0, 500);
                program_regs(lo_i[15:0], hi_i[15:0], pmin_w, pmax_w, freq[15:0],
                             16'($urandom_range(1, 65535)));
            end else begin
                program_regs(lo_i[15:0], hi_i[15:0], pmin_w, pmax_w, freq[15:0],
                             16'($urandom_range(1, 65535)));
            end
            rx_mode = (phase == 0) ? RX_ALWAYS : t_rx_mode'($urandom_range(0, 2));
            tx_gap_max = (phase == 0) ? 0 : $urandom_range(0, 8);
            lo_i = thr_low_r;
            hi_i = thr_high_r;
            for (int n = 0; n < 150; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: thr_i = $urandom;
                    2: thr_i = ($urandom_range(0, 1) ? hi_i : lo_i) + $urandom_range(0, 2) - 1;
                    default: begin
                        if (hi_i > lo_i) thr_i = lo_i + $urandom_range(0, hi_i - lo_i);
                        else thr_i = $urandom;
                    end
                endcase
                send_beat(3'($urandom_range(0, 7)), thr_i[15:0]);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_corner_settings();
        test_random_settings();
        wait_idle();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_levels.size()));
        end
        $display("Sent %0d beats and checked %0d results across %0d register writes.",
                 n_sent, n_checked, n_writes);
        $display("%0d results carried the range error flag; %0d mismatches seen.",
                 n_flagged, fail_count);
        if (fail_count == 0) begin
            $display("PASS throttle_to_pwm_level_core");
        end else begin
            $display("FAIL throttle_to_pwm_level_core");
        end
        $finish;
    end

endmodule

/* sim.f */
design/thrpwm_pkg.sv
design/thrpwm_div.sv
design/throttle_to_pwm_level_core.sv
design/thrpwm_chk.sv
tb/testbench.sv
